@@ design/md5sh_pkg.sv @@
// MD5 stream hasher shared types, constants and round tables.
package md5sh_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5sh_abcd_type;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Block word used by round r.
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] r4;
      logic [3:0] idx;
      r4 = r[3:0];
      case (r[5:4])
         2'd0:    idx = r4;
         2'd1:    idx = {r4[1:0], 2'b00} + r4 + 4'd1;
         2'd2:    idx = {r4[2:0], 1'b0} + r4 + 4'd5;
         default: idx = {r4[0], 3'b000} - r4;
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] round_shift(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'h0: s = 5'd7;
         4'h1: s = 5'd12;
         4'h2: s = 5'd17;
         4'h3: s = 5'd22;
         4'h4: s = 5'd5;
         4'h5: s = 5'd9;
         4'h6: s = 5'd14;
         4'h7: s = 5'd20;
         4'h8: s = 5'd4;
         4'h9: s = 5'd11;
         4'ha: s = 5'd16;
         4'hb: s = 5'd23;
         4'hc: s = 5'd6;
         4'hd: s = 5'd10;
         4'he: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

@@ design/md5sh_if.sv @@
// Valid/ready stream interfaces for the hasher's byte input and digest output.
interface md5sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

interface md5sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

@@ design/md5sh_round.sv @@
// One MD5 round step on the working registers.
module md5sh_round (
   input  logic [5:0]                 round_idx,
   input  md5sh_pkg::md5sh_abcd_type  state_in,
   input  logic [31:0]                msg_word,
   output md5sh_pkg::md5sh_abcd_type  state_out
);
   import md5sh_pkg::*;

   logic [31:0] f;
   logic [31:0] sum;
   logic [63:0] rot64;
   logic [31:0] rot;

   always_comb begin
      case (round_idx[5:4])
         2'd0:    f = (state_in.b & state_in.c) | (~state_in.b & state_in.d);
         2'd1:    f = (state_in.b & state_in.d) | (state_in.c & ~state_in.d);
         2'd2:    f = state_in.b ^ state_in.c ^ state_in.d;
         default: f = state_in.c ^ (state_in.b | ~state_in.d);
      endcase
   end

   assign sum   = state_in.a + f + ROUND_CONST[round_idx] + msg_word;
   // upper half of the doubled word shifted left is the rotate
   assign rot64 = {sum, sum} << round_shift(round_idx);
   assign rot   = rot64[63:32];

   assign state_out.a = state_in.d;
   assign state_out.b = state_in.b + rot;
   assign state_out.c = state_in.b;
   assign state_out.d = state_in.c;

endmodule

@@ design/md5_stream_hasher_core.sv @@
// MD5 stream hasher: one byte per word in, four digest words out per message.
// A byte is taken when idle; a full block runs through prime, 64 rounds and fold on the
// single round unit reading the 16-word block memory.
// End of message: padding bytes, then one or two blocks, then 4 words.
// Throughput: one byte per cycle in idle; stalls during blocks, padding and digest out.
// Reset (synchronous): chaining words to the MD5 IV, position and bit count to zero.
module md5_stream_hasher_core (
   input logic       clock,
   input logic       reset,
   md5sh_req_if.sink   req,
   md5sh_rsp_if.source rsp
);
   import md5sh_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_PRIME = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_FOLD  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [2:0]     state_ff;
   logic [1:0]     phase_ff;
   logic [2:0]     len_idx_ff;
   logic           pad_on_ff;
   logic [5:0]     pos_ff;
   logic [63:0]    bitlen_ff;
   logic [31:0]    word_ff;
   logic [5:0]     round_ff;
   logic [1:0]     out_idx_ff;
   logic [31:0]    chain_ff [4];
   md5sh_abcd_type work_ff;
   logic [31:0]    rdata_ff;
   logic [31:0]    mem [16];

   logic           req_fire;
   logic           rsp_fire;
   logic           store_en;
   logic [7:0]     store_byte;
   logic [5:0]     pos_in;
   logic [31:0]    word_in;
   logic           mem_we;
   logic           wrap;
   logic [3:0]     rd_addr;
   md5sh_abcd_type round_out;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   always_comb begin
      store_en   = 1'b0;
      store_byte = '0;
      if (state_ff == S_IDLE && req_fire && req.has_byte) begin
         store_en   = 1'b1;
         store_byte = req.data_byte;
      end else if (state_ff == S_PAD) begin
         store_en = 1'b1;
         case (phase_ff)
            PH_MARK: store_byte = PAD_MARK;
            PH_LEN:  store_byte = bitlen_ff[{len_idx_ff, 3'b000} +: 8];
            default: store_byte = '0;
         endcase
      end
   end

   assign pos_in  = pos_ff + 6'd1;
   // lane 0 starts a fresh word, the others merge into it
   assign word_in = (pos_ff[1:0] == 2'd0) ? {24'd0, store_byte}
                  : word_ff | ({24'd0, store_byte} << {pos_ff[1:0], 3'b000});
   assign mem_we  = store_en && (pos_ff[1:0] == 2'd3);
   assign wrap    = store_en && (pos_ff == 6'd63);
   // prefetch the word for the next round
   assign rd_addr = (state_ff == S_PRIME) ? msg_index(6'd0) : msg_index(round_ff + 6'd1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff[5:2]] <= word_in;
      end
      rdata_ff <= mem[rd_addr];
   end

   md5sh_round u_round (
      .round_idx (round_ff),
      .state_in  (work_ff),
      .msg_word  (rdata_ff),
      .state_out (round_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_MARK;
         len_idx_ff  <= '0;
         pad_on_ff   <= 1'b0;
         pos_ff      <= '0;
         bitlen_ff   <= '0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
      end else begin
         if (store_en) begin
            word_ff <= word_in;
            pos_ff  <= pos_in;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req.has_byte) begin
                     bitlen_ff <= bitlen_ff + 64'd8;
                  end
                  if (req.end_of_message) begin
                     pad_on_ff <= 1'b1;
                     phase_ff  <= PH_MARK;
                  end
                  if (wrap) begin
                     state_ff <= S_PRIME;
                  end else if (req.end_of_message) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               case (phase_ff)
                  PH_MARK: phase_ff <= (pos_in == LEN_POS) ? PH_LEN : PH_ZERO;
                  PH_ZERO: begin
                     if (pos_in == LEN_POS) begin
                        phase_ff <= PH_LEN;
                     end
                  end
                  default: begin
                     len_idx_ff <= len_idx_ff + 3'd1;
                     if (len_idx_ff == 3'd7) begin
                        phase_ff <= PH_DONE;
                     end
                  end
               endcase
               if (wrap) begin
                  state_ff <= S_PRIME;
               end
            end
            S_PRIME: begin
               work_ff.a <= chain_ff[0];
               work_ff.b <= chain_ff[1];
               work_ff.c <= chain_ff[2];
               work_ff.d <= chain_ff[3];
               round_ff  <= '0;
               state_ff  <= S_ROUND;
            end
            S_ROUND: begin
               work_ff  <= round_out;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               chain_ff[0] <= chain_ff[0] + work_ff.a;
               chain_ff[1] <= chain_ff[1] + work_ff.b;
               chain_ff[2] <= chain_ff[2] + work_ff.c;
               chain_ff[3] <= chain_ff[3] + work_ff.d;
               if (phase_ff == PH_DONE) begin
                  out_idx_ff <= '0;
                  state_ff   <= S_OUT;
               end else if (pad_on_ff) begin
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_OUT: begin
               if (rsp_fire) begin
                  out_idx_ff <= out_idx_ff + 2'd1;
                  if (out_idx_ff == 2'd3) begin
                     chain_ff[0] <= IV_A;
                     chain_ff[1] <= IV_B;
                     chain_ff[2] <= IV_C;
                     chain_ff[3] <= IV_D;
                     pos_ff      <= '0;
                     bitlen_ff   <= '0;
                     pad_on_ff   <= 1'b0;
                     phase_ff    <= PH_MARK;
                     len_idx_ff  <= '0;
                     state_ff    <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.digest_word = chain_ff[out_idx_ff];
   assign rsp.digest_last = (out_idx_ff == 2'd3);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("input taken while digest pending");

   a_clean_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp.digest_last |=> pos_ff == 6'd0 && bitlen_ff == 64'd0)
      else $error("state not cleared after digest");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && round_ff == 6'd63 |=> state_ff == S_FOLD)
      else $error("compression did not end after 64 rounds");

   a_no_write_in_rounds: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_IDLE || state_ff == S_PAD)
      else $error("block store written during compression");
`endif

endmodule
